// File: rtl/core/serial_command_line_decoder_top_assert.svh
// Assertion macros shared by the serial command line decoder RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef SERIAL_COMMAND_LINE_DECODER_TOP_ASSERT_SVH
`define SERIAL_COMMAND_LINE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SCLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scld assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SCLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scld assertion failed");

`endif

// File: rtl/core/scld_pkg.sv
// Shared types and constants for the serial command line decoder.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package scld_pkg;

   localparam int LINE_CAPACITY_DEFAULT = 64;
   localparam int LEN_W                 = 6;
   localparam int TICK_W                = 16;
   localparam int CSR_ADDR_W            = 4;
   localparam int CSR_DATA_W            = 32;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [TICK_W-1:0] HEARTBEAT_RESET = 16'd500;
   localparam logic [TICK_W-1:0] PULSE_RESET     = 16'd120;
   localparam logic [TICK_W-1:0] FLASH_RESET     = 16'd120;

   typedef enum logic [3:0] {
      REPLY_NONE    = 4'd0,
      REPLY_PONG    = 4'd1,
      REPLY_IDLE    = 4'd2,
      REPLY_RUN     = 4'd3,
      REPLY_DONE    = 4'd4,
      REPLY_ERROR   = 4'd5,
      REPLY_HELP    = 4'd6,
      REPLY_UNKNOWN = 4'd7,
      REPLY_LONG    = 4'd8
   } reply_type;

   typedef enum logic [1:0] {
      REG_HEARTBEAT = 2'd0,
      REG_PULSE     = 2'd1,
      REG_FLASH     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [TICK_W-1:0] heartbeat_ticks;
      logic [TICK_W-1:0] rx_pulse_ticks;
      logic [TICK_W-1:0] done_flash_ticks;
   } cfg_type;

   typedef struct packed {
      reply_type         reply;
      logic [LEN_W-1:0]  line_length;
   } line_result_type;

endpackage

`default_nettype wire

// File: rtl/core/serial_command_line_decoder_top.sv
// Top level of the serial command line decoder: input register, line and
// indicator logic, result register. Depends on scld_pkg, scld_csr, scld_line,
// scld_ind and serial_command_line_decoder_top_assert.svh.
//
// Each transfer on req_ is a received byte (req_action 0) or a one millisecond
// tick (req_action 1), and yields exactly one transfer on rsp_ carrying the
// reply code, the length of a just-completed line and the four LED levels.
// The block takes one item per clock cycle while rsp_ready stays high: an item
// lands in the input register at its transfer edge and its result is then
// loaded into the result register. While a result waits on rsp_ready the
// input register takes one more item if it is empty and then holds it, with
// req_ready low, until the result transfer completes; rsp_ready reaches
// req_ready through combinational logic. Configuration registers sit at byte
// addresses 0 (heartbeat_ticks), 4 (rx_pulse_ticks) and 8 (done_flash_ticks);
// write them only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_command_line_decoder_top_assert.svh"

module serial_command_line_decoder_top #(
   parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_action,
   input  wire logic [7:0]                          req_rx_byte,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [3:0]                          rsp_reply,
   output      logic [scld_pkg::LEN_W-1:0]          rsp_line_length,
   output      logic [3:0]                          rsp_leds,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [scld_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [scld_pkg::CSR_DATA_W-1:0]     pwdata,
   output      logic [scld_pkg::CSR_DATA_W-1:0]     prdata,
   output      logic                                pready
);

   scld_pkg::cfg_type          cfg;
   scld_pkg::line_result_type  line_res;
   logic [3:0]                 leds_in;

   logic                       s1_vld_ff;
   logic                       s1_action_ff;
   logic [7:0]                 s1_byte_ff;
   logic                       advance;

   logic                       rsp_vld_ff;
   scld_pkg::reply_type        rsp_reply_ff;
   logic [scld_pkg::LEN_W-1:0] rsp_len_ff;
   logic [3:0]                 rsp_leds_ff;

   // Move the input register forward when the result register is free
   assign advance   = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_action_ff <= req_action;
         s1_byte_ff   <= req_rx_byte;
      end
   end

   scld_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scld_line #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_line (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .byte_en (!s1_action_ff),
      .rx_byte (s1_byte_ff),
      .result  (line_res)
   );

   scld_ind u_ind (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .tick_en (s1_action_ff),
      .reply   (line_res.reply),
      .leds_in (leds_in)
   );

   // Result register: load on advance, drop once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_reply_ff <= line_res.reply;
         rsp_len_ff   <= line_res.line_length;
         rsp_leds_ff  <= leds_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_reply       = rsp_reply_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_leds        = rsp_leds_ff;

   // Checks
   `SCLD_ASSERT_IMP(a_stall_only_when_full, clock, reset, !req_ready, s1_vld_ff && rsp_vld_ff && !rsp_ready)
   `SCLD_ASSERT_NXT(a_tick_gives_no_reply, clock, reset, advance && s1_action_ff, rsp_reply_ff == scld_pkg::REPLY_NONE && rsp_len_ff == '0)
   `SCLD_ASSERT_NXT(a_result_from_stage, clock, reset, !rsp_vld_ff, !rsp_vld_ff || $past(s1_vld_ff))
   `SCLD_ASSERT_IMP(a_overflow_lights_error, clock, reset, rsp_vld_ff && rsp_reply_ff == scld_pkg::REPLY_LONG, rsp_leds_ff[3] && rsp_len_ff == '0)

endmodule

`default_nettype wire

// File: rtl/core/scld_csr.sv
// APB-style configuration registers of the serial command line decoder.
// Depends on scld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scld_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [scld_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire logic [scld_pkg::CSR_DATA_W-1:0]       pwdata,
   output      logic [scld_pkg::CSR_DATA_W-1:0]       prdata,
   output      logic                                  pready,
   output      scld_pkg::cfg_type                     cfg
);

   scld_pkg::cfg_type       cfg_ff, cfg_in;
   scld_pkg::reg_index_type reg_index;
   logic                    wr_en;

   assign reg_index = scld_pkg::reg_index_type'(paddr[scld_pkg::CSR_ADDR_W-1:2]);
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Update the addressed register on a write transfer
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            scld_pkg::REG_HEARTBEAT: cfg_in.heartbeat_ticks  = pwdata[scld_pkg::TICK_W-1:0];
            scld_pkg::REG_PULSE:     cfg_in.rx_pulse_ticks   = pwdata[scld_pkg::TICK_W-1:0];
            scld_pkg::REG_FLASH:     cfg_in.done_flash_ticks = pwdata[scld_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heartbeat_ticks  <= scld_pkg::HEARTBEAT_RESET;
         cfg_ff.rx_pulse_ticks   <= scld_pkg::PULSE_RESET;
         cfg_ff.done_flash_ticks <= scld_pkg::FLASH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (reg_index)
         scld_pkg::REG_HEARTBEAT:
            prdata = scld_pkg::CSR_DATA_W'(cfg_ff.heartbeat_ticks);
         scld_pkg::REG_PULSE:
            prdata = scld_pkg::CSR_DATA_W'(cfg_ff.rx_pulse_ticks);
         scld_pkg::REG_FLASH:
            prdata = scld_pkg::CSR_DATA_W'(cfg_ff.done_flash_ticks);
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/scld_line.sv
// Line assembly and command matching: line count, first four characters,
// terminator handling and overflow. Depends on scld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scld_line #(
   parameter int LINE_CAPACITY = scld_pkg::LINE_CAPACITY_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic                     byte_en,
   input  wire logic [7:0]               rx_byte,
   output      scld_pkg::line_result_type result
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_HEAD = CNT_W'(4);

   localparam logic [31:0] WORD_PING = "PING";
   localparam logic [31:0] WORD_IDLE = "IDLE";
   localparam logic [23:0] WORD_RUN  = "RUN";
   localparam logic [31:0] WORD_DONE = "DONE";
   localparam logic [23:0] WORD_ERR  = "ERR";
   localparam logic [31:0] WORD_HELP = "HELP";
   localparam logic [7:0]  CHAR_P    = "P";
   localparam logic [7:0]  CHAR_I    = "I";
   localparam logic [7:0]  CHAR_R    = "R";
   localparam logic [7:0]  CHAR_D    = "D";
   localparam logic [7:0]  CHAR_E    = "E";
   localparam logic [7:0]  CHAR_H    = "H";

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       head_ff [4];
   logic             head_wr;
   logic [7:0]       ch_upper;
   logic             is_term;
   logic             len1, len3, len4;
   logic [31:0]      word4;
   logic [23:0]      word3;
   logic [7:0]       word1;

   assign is_term  = (rx_byte == scld_pkg::CHAR_CR) || (rx_byte == scld_pkg::CHAR_LF);
   assign ch_upper = (rx_byte >= 8'h61 && rx_byte <= 8'h7A) ? (rx_byte - 8'h20) : rx_byte;

   assign len1  = (count_ff == CNT_W'(1));
   assign len3  = (count_ff == CNT_W'(3));
   assign len4  = (count_ff == CNT_W'(4));
   assign word4 = {head_ff[0], head_ff[1], head_ff[2], head_ff[3]};
   assign word3 = word4[31:8];
   assign word1 = head_ff[0];

   // Decode the byte: append, end and match the line, or drop it on overflow
   always_comb begin
      count_in           = count_ff;
      head_wr            = 1'b0;
      result.reply       = scld_pkg::REPLY_NONE;
      result.line_length = '0;
      if (byte_en) begin
         if (is_term) begin
            if (count_ff != '0) begin
               count_in           = '0;
               result.line_length = scld_pkg::LEN_W'(count_ff);
               if ((len4 && word4 == WORD_PING) || (len1 && word1 == CHAR_P)) begin
                  result.reply = scld_pkg::REPLY_PONG;
               end else if ((len4 && word4 == WORD_IDLE) || (len1 && word1 == CHAR_I)) begin
                  result.reply = scld_pkg::REPLY_IDLE;
               end else if ((len3 && word3 == WORD_RUN) || (len1 && word1 == CHAR_R)) begin
                  result.reply = scld_pkg::REPLY_RUN;
               end else if ((len4 && word4 == WORD_DONE) || (len1 && word1 == CHAR_D)) begin
                  result.reply = scld_pkg::REPLY_DONE;
               end else if ((len3 && word3 == WORD_ERR) || (len1 && word1 == CHAR_E)) begin
                  result.reply = scld_pkg::REPLY_ERROR;
               end else if ((len4 && word4 == WORD_HELP) || (len1 && word1 == CHAR_H)) begin
                  result.reply = scld_pkg::REPLY_HELP;
               end else begin
                  result.reply = scld_pkg::REPLY_UNKNOWN;
               end
            end
         end else if (count_ff < CNT_LAST) begin
            head_wr  = (count_ff < CNT_HEAD);
            count_in = count_ff + CNT_W'(1);
         end else begin
            count_in     = '0;
            result.reply = scld_pkg::REPLY_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step_en) begin
         count_ff <= count_in;
      end
   end

   // Keep the first four characters of the line
   always_ff @(posedge clock) begin
      if (step_en && head_wr) begin
         head_ff[count_ff[1:0]] <= ch_upper;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/scld_ind.sv
// Indicator state: running and error flags, heartbeat, receive pulse and
// DONE flash countdowns, and the LED pattern. Depends on scld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scld_ind (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire scld_pkg::cfg_type  cfg,
   input  wire logic               step_en,
   input  wire logic               tick_en,
   input  wire scld_pkg::reply_type reply,
   output      logic [3:0]         leds_in
);

   localparam logic [scld_pkg::TICK_W-1:0] TICK_MAX = '1;
   localparam logic [scld_pkg::TICK_W-1:0] TICK_ONE = scld_pkg::TICK_W'(1);

   logic                        run_ff, run_in;
   logic                        err_ff, err_in;
   logic                        hb_ff, hb_in;
   logic [scld_pkg::TICK_W-1:0] elapsed_ff, elapsed_in;
   logic [scld_pkg::TICK_W-1:0] pulse_ff, pulse_in;
   logic [scld_pkg::TICK_W-1:0] flash_ff, flash_in;
   logic [scld_pkg::TICK_W-1:0] elapsed_inc;

   assign elapsed_inc = (elapsed_ff != TICK_MAX) ? (elapsed_ff + TICK_ONE) : elapsed_ff;

   // Advance timers on a tick, apply the line outcome otherwise
   always_comb begin
      run_in     = run_ff;
      err_in     = err_ff;
      hb_in      = hb_ff;
      elapsed_in = elapsed_ff;
      pulse_in   = pulse_ff;
      flash_in   = flash_ff;
      if (tick_en) begin
         if (elapsed_inc >= cfg.heartbeat_ticks) begin
            hb_in      = !hb_ff;
            elapsed_in = '0;
         end else begin
            elapsed_in = elapsed_inc;
         end
         if (pulse_ff != '0) pulse_in = pulse_ff - TICK_ONE;
         if (flash_ff != '0) flash_in = flash_ff - TICK_ONE;
      end else begin
         case (reply) inside
            scld_pkg::REPLY_IDLE: begin
               run_in = 1'b0;
               err_in = 1'b0;
            end
            scld_pkg::REPLY_DONE: begin
               run_in   = 1'b0;
               err_in   = 1'b0;
               flash_in = cfg.done_flash_ticks;
            end
            scld_pkg::REPLY_RUN: begin
               run_in = 1'b1;
               err_in = 1'b0;
            end
            scld_pkg::REPLY_ERROR: begin
               run_in = 1'b0;
               err_in = 1'b1;
            end
            scld_pkg::REPLY_UNKNOWN, scld_pkg::REPLY_LONG: begin
               err_in = 1'b1;
            end
            default: ;
         endcase
         // Restart the receive pulse on every completed line
         if (reply != scld_pkg::REPLY_NONE && reply != scld_pkg::REPLY_LONG) begin
            pulse_in = cfg.rx_pulse_ticks;
         end
      end
   end

   // LED pattern after this step; the flash overrides everything
   assign leds_in = (flash_in != '0) ? 4'hF : {err_in, (pulse_in != '0), run_in, hb_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff     <= 1'b0;
         err_ff     <= 1'b0;
         hb_ff      <= 1'b0;
         elapsed_ff <= '0;
         pulse_ff   <= '0;
         flash_ff   <= '0;
      end else if (step_en) begin
         run_ff     <= run_in;
         err_ff     <= err_in;
         hb_ff      <= hb_in;
         elapsed_ff <= elapsed_in;
         pulse_ff   <= pulse_in;
         flash_ff   <= flash_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/serial_command_line_decoder_top_tb.sv
// Self-checking bench for serial_command_line_decoder_top: queued byte and tick
// traffic, a per-item predictor of replies and LED levels, APB timing setup.
// Depends on scld_pkg and the decoder RTL.
`timescale 1ns / 1ps

module serial_command_line_decoder_top_tb;

   localparam int       LINE_CAP = scld_pkg::LINE_CAPACITY_DEFAULT;
   localparam logic     ACT_BYTE = 1'b0;
   localparam logic     ACT_TICK = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } serial_item_type;

   typedef struct {
      scld_pkg::reply_type          reply;
      logic [scld_pkg::LEN_W-1:0]   line_length;
      logic [3:0]                   leds;
   } expect_type;

   typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_EVERY_THIRD} sink_mode_type;

   // DUT ports
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_action = 1'b0;
   logic [7:0]                        req_rx_byte = 8'h00;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [3:0]                        rsp_reply;
   logic [scld_pkg::LEN_W-1:0]        rsp_line_length;
   logic [3:0]                        rsp_leds;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [scld_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [scld_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   logic [scld_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   // Traffic bookkeeping
   serial_item_type  pending_items[$];
   expect_type       expected_results[$];
   serial_item_type  next_item;
   expect_type       expected_head;
   int               items_queued = 0;
   int               items_accepted = 0;
   bit               req_taken = 1'b0;
   bit               failed = 1'b0;
   int               burst_left = 1;
   int               gap_left = 0;
   sink_mode_type    sink_mode = SINK_OPEN;
   int               sink_hold = 0;

   // Predictor copy of timing setup and decoder state
   logic [scld_pkg::TICK_W-1:0] hb_ticks_cfg = scld_pkg::HEARTBEAT_RESET;
   logic [scld_pkg::TICK_W-1:0] pulse_ticks_cfg = scld_pkg::PULSE_RESET;
   logic [scld_pkg::TICK_W-1:0] flash_ticks_cfg = scld_pkg::FLASH_RESET;
   int                          chars_pending = 0;
   logic [7:0]                  head_chars[4] = '{default: 8'h00};
   bit                          running_on = 1'b0;
   bit                          error_on = 1'b0;
   bit                          hb_level = 1'b0;
   logic [scld_pkg::TICK_W-1:0] heartbeat_count = '0;
   logic [scld_pkg::TICK_W-1:0] pulse_left = '0;
   logic [scld_pkg::TICK_W-1:0] flash_left = '0;

   string command_words[12] = '{"PING", "P", "IDLE", "I", "RUN", "R",
                                "DONE", "D", "ERR", "E", "HELP", "H"};

   serial_command_line_decoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_reply       (rsp_reply),
      .rsp_line_length (rsp_line_length),
      .rsp_leds        (rsp_leds),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Exact match of the pending line against a right-aligned word of n chars
   function automatic bit head_matches(input logic [31:0] word, input int n);
      if (chars_pending != n) return 1'b0;
      for (int i = 0; i < n; i++)
         if (head_chars[i] != word[8*(n-1-i) +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   // Advance the decoder state by one item and queue the result it yields
   function automatic void predict_line_result(input logic act, input logic [7:0] rx);
      expect_type res;
      logic [7:0] ch;
      res.reply = scld_pkg::REPLY_NONE;
      res.line_length = '0;
      ch = rx;
      if (act == ACT_TICK) begin
         if (heartbeat_count != '1) heartbeat_count++;
         if (heartbeat_count >= hb_ticks_cfg) begin
            hb_level = ~hb_level;
            heartbeat_count = '0;
         end
         if (pulse_left != 0) pulse_left--;
         if (flash_left != 0) flash_left--;
      end else if (ch == scld_pkg::CHAR_CR || ch == scld_pkg::CHAR_LF) begin
         // Terminator: decode a non-empty line, ignore an empty one
         if (chars_pending != 0) begin
            res.line_length = chars_pending[scld_pkg::LEN_W-1:0];
            if (head_matches("PING", 4) || head_matches("P", 1)) begin
               res.reply = scld_pkg::REPLY_PONG;
            end else if (head_matches("IDLE", 4) || head_matches("I", 1)) begin
               running_on = 1'b0; error_on = 1'b0; res.reply = scld_pkg::REPLY_IDLE;
            end else if (head_matches("RUN", 3) || head_matches("R", 1)) begin
               running_on = 1'b1; error_on = 1'b0; res.reply = scld_pkg::REPLY_RUN;
            end else if (head_matches("DONE", 4) || head_matches("D", 1)) begin
               running_on = 1'b0; error_on = 1'b0; res.reply = scld_pkg::REPLY_DONE;
               flash_left = flash_ticks_cfg;
            end else if (head_matches("ERR", 3) || head_matches("E", 1)) begin
               running_on = 1'b0; error_on = 1'b1; res.reply = scld_pkg::REPLY_ERROR;
            end else if (head_matches("HELP", 4) || head_matches("H", 1)) begin
               res.reply = scld_pkg::REPLY_HELP;
            end else begin
               error_on = 1'b1; res.reply = scld_pkg::REPLY_UNKNOWN;
            end
            pulse_left = pulse_ticks_cfg;
            chars_pending = 0;
         end
      end else if (chars_pending < LINE_CAP - 1) begin
         // Append an uppercased character, keep only the first four
         if (ch >= "a" && ch <= "z") ch = ch - 8'h20;
         if (chars_pending < 4) head_chars[chars_pending] = ch;
         chars_pending++;
      end else begin
         // Line overflow: drop the line and the byte
         chars_pending = 0;
         error_on = 1'b1;
         res.reply = scld_pkg::REPLY_LONG;
      end
      res.leds = (flash_left != 0) ? 4'hF :
                 {error_on, pulse_left != 0, running_on, hb_level};
      expected_results.push_back(res);
   endfunction

   task automatic push_item(input logic act, input logic [7:0] b);
      pending_items.push_back('{action: act, rx_byte: b});
      items_queued++;
   endtask

   task automatic push_line(input string text, input logic [7:0] term);
      for (int i = 0; i < text.len(); i++) push_item(ACT_BYTE, text[i]);
      push_item(ACT_BYTE, term);
   endtask

   function automatic logic [7:0] pick_terminator();
      return ($urandom_range(0, 1) != 0) ? scld_pkg::CHAR_CR : scld_pkg::CHAR_LF;
   endfunction

   // Any byte but a terminator
   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == scld_pkg::CHAR_CR || b == scld_pkg::CHAR_LF) b = b ^ 8'h40;
      return b;
   endfunction

   // Command lines, some bent into near misses, plus garbage, long lines, ticks
   task automatic run_random_traffic(input int target);
      int         start;
      int         pick;
      int         count;
      logic [7:0] text[$];
      string      word;
      start = items_queued;
      while (items_queued - start < target) begin
         pick = $urandom_range(0, 99);
         text.delete();
         if (pick < 48) begin
            word = command_words[$urandom_range(0, 11)];
            for (int i = 0; i < word.len(); i++) text.push_back(word[i]);
            // Bend some words into near misses
            if (pick >= 35) begin
               case ($urandom_range(0, 2))
                  0: void'(text.pop_back());
                  1: text.push_back(8'("A" + $urandom_range(0, 25)));
                  default: text[$urandom_range(0, text.size() - 1)] =
                              8'("A" + $urandom_range(0, 25));
               endcase
            end
            foreach (text[i])
               push_item(ACT_BYTE, ($urandom_range(0, 1) != 0) ? (text[i] | 8'h20) : text[i]);
            push_item(ACT_BYTE, pick_terminator());
         end else if (pick < 64) begin
            // Short garbage lines, or lines around the capacity edge
            count = (pick < 60) ? $urandom_range(1, 10) : $urandom_range(58, 70);
            repeat (count) push_item(ACT_BYTE, pick_text_byte());
            push_item(ACT_BYTE, pick_terminator());
         end else if (pick < 92) begin
            count = $urandom_range(1, 20);
            repeat (count) push_item(ACT_TICK, 8'($urandom_range(0, 255)));
         end else begin
            push_item(ACT_BYTE, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Hold until every queued item has been accepted and answered, then settle
   task automatic wait_for_drain();
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, then release
   task automatic write_reg(input scld_pkg::reg_index_type idx,
                            input logic [scld_pkg::TICK_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= scld_pkg::CSR_ADDR_W'(4 * int'(idx));
      pwdata <= {16'($urandom), value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_timing(input logic [scld_pkg::TICK_W-1:0] hb,
                             input logic [scld_pkg::TICK_W-1:0] pulse,
                             input logic [scld_pkg::TICK_W-1:0] flash);
      write_reg(scld_pkg::REG_HEARTBEAT, hb);
      write_reg(scld_pkg::REG_PULSE, pulse);
      write_reg(scld_pkg::REG_FLASH, flash);
      hb_ticks_cfg = hb;
      pulse_ticks_cfg = pulse;
      flash_ticks_cfg = flash;
   endtask

   // Sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_action <= next_item.action;
            req_rx_byte <= next_item.rx_byte;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: switch between stall patterns every so often
   always @(negedge clock) begin
      if (sink_hold == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         sink_hold = $urandom_range(16, 128);
      end else begin
         sink_hold--;
      end
      case (sink_mode)
         SINK_OPEN:  rsp_ready <= 1'b1;
         SINK_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         SINK_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ready <= (sink_hold % 3 == 0);
      endcase
   end

   // Check result transfers, then predict for the accepted input transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: reply %0d, line_length %0d, leds %h",
                      rsp_reply, rsp_line_length, rsp_leds);
               failed = 1'b1;
            end else begin
               expected_head = expected_results.pop_front();
               if (rsp_reply !== expected_head.reply) begin
                  $error("reply: expected %0d, actual %0d", expected_head.reply, rsp_reply);
                  failed = 1'b1;
               end
               if (rsp_line_length !== expected_head.line_length) begin
                  $error("line_length: expected %0d, actual %0d",
                         expected_head.line_length, rsp_line_length);
                  failed = 1'b1;
               end
               if (rsp_leds !== expected_head.leds) begin
                  $error("leds: expected %h, actual %h", expected_head.leds, rsp_leds);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_line_result(req_action, req_rx_byte);
            items_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every command, case folding, empty line, zero and high bytes
      push_item(ACT_TICK, 8'hFF);
      push_line("p", scld_pkg::CHAR_CR);
      push_line("PiNg", scld_pkg::CHAR_LF);
      push_item(ACT_BYTE, scld_pkg::CHAR_LF);
      push_line("r", scld_pkg::CHAR_CR);
      push_line("d", scld_pkg::CHAR_LF);
      push_line("e", scld_pkg::CHAR_CR);
      push_line("h", scld_pkg::CHAR_LF);
      push_line("I", scld_pkg::CHAR_CR);
      push_item(ACT_BYTE, 8'h00);
      push_item(ACT_BYTE, scld_pkg::CHAR_LF);
      push_item(ACT_BYTE, 8'hFF);
      push_item(ACT_BYTE, 8'h60);
      push_item(ACT_BYTE, 8'h7B);
      push_item(ACT_BYTE, scld_pkg::CHAR_CR);
      push_item(ACT_TICK, 8'h00);
      run_random_traffic(210);
      wait_for_drain();

      // Walk the timing setup through its extremes and a few small values
      set_timing(16'd1, 16'd0, 16'd0);
      run_random_traffic(210);
      wait_for_drain();
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random_traffic(210);
      wait_for_drain();
      set_timing(16'd2, 16'd3, 16'd5);
      run_random_traffic(210);
      wait_for_drain();
      set_timing(16'd7, 16'd1, 16'd40);
      run_random_traffic(210);
      wait_for_drain();

      if (failed) begin
         $display("Verification failed");
      end else begin
         $display("Verification passed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/scld_pkg.sv
rtl/core/scld_csr.sv
rtl/core/scld_line.sv
rtl/core/scld_ind.sv
rtl/core/serial_command_line_decoder_top.sv
tb/serial_command_line_decoder_top_tb.sv
